@@ rtl/rms_pkg.sv @@
// rms_pkg: shared types and constants for the windowed RMS level meter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package rms_pkg;

  localparam int MAG_W  = 24;   // aligned sample magnitude, at most 2^23
  localparam int SQ_W   = 47;   // square of the magnitude, at most 2^46
  localparam int SUM_W  = 62;   // saturating sum of squares
  localparam int CNT_W  = 16;   // samples in the window
  localparam int ROOT_W = 31;   // root of a 62-bit mean
  localparam int REM_W  = 32;   // root remainder, at most 2 * root
  localparam int UNIT_W = 34;   // shared compare-subtract width
  localparam int STEP_W = 6;    // iteration counter

  localparam logic [CNT_W-1:0]  MAX_WINDOW_SAMPLES = 16'd32768;
  localparam logic [SUM_W-1:0]  SUM_MAX            = {SUM_W{1'b1}};
  localparam logic [STEP_W-1:0] DIV_STEPS_M1       = 6'(SUM_W - 1);
  localparam logic [STEP_W-1:0] ROOT_STEPS_M1      = 6'(ROOT_W - 1);

  // sample_format codes
  localparam logic [1:0] FMT_U8  = 2'd0;
  localparam logic [1:0] FMT_S16 = 2'd1;
  localparam logic [1:0] FMT_S24 = 2'd2;
  localparam logic [1:0] FMT_NONE = 2'd3;

  // register index (paddr[2])
  localparam logic REG_SAMPLE_FORMAT = 1'b0;

  typedef struct packed {
    logic              ge;    // a >= b
    logic [UNIT_W-1:0] diff;  // a - b
  } cmpsub_res_t;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SQR  = 6'b000010,
    S_ACC  = 6'b000100,
    S_DIV  = 6'b001000,
    S_ROOT = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

endpackage

@@ rtl/rms_decode.sv @@
// rms_decode: turns a raw sample word into its magnitude aligned to signed 24 bits.
// Depends on rms_pkg for the format codes and widths.
`timescale 1ns / 1ps

module rms_decode import rms_pkg::*; (
  input  logic [1:0]       fmt,
  input  logic [23:0]      word,
  output logic [MAG_W-1:0] mag
);

  logic [8:0]  m8;
  logic [16:0] m16;
  logic [24:0] m24;

  always_comb begin
    m8  = word[7] ? {2'b0, word[6:0]} : (9'd128 - {1'b0, word[7:0]});
    m16 = word[15] ? (17'h10000 - {1'b0, word[15:0]}) : {1'b0, word[15:0]};
    m24 = word[23] ? (25'h1000000 - {1'b0, word}) : {1'b0, word};
    unique case (fmt)
      FMT_U8:   mag = {m8[7:0], 16'd0};
      FMT_S16:  mag = {m16[15:0], 8'd0};
      FMT_S24:  mag = m24[MAG_W-1:0];
      FMT_NONE: mag = '0;
      default:  mag = '0;
    endcase
  end

endmodule

@@ rtl/rms_cmpsub.sv @@
// rms_cmpsub: the one compare-subtract unit shared by the divide and root steps.
// Depends on rms_pkg for the unit width and result struct.
`timescale 1ns / 1ps

module rms_cmpsub import rms_pkg::*; (
  input  logic [UNIT_W-1:0] a,
  input  logic [UNIT_W-1:0] b,
  output cmpsub_res_t       res
);

  logic [UNIT_W:0] d;

  assign d        = {1'b0, a} - {1'b0, b};
  assign res.ge   = ~d[UNIT_W];
  assign res.diff = d[UNIT_W-1:0];

endmodule

@@ rtl/windowed_rms_level_meter.sv @@
// windowed_rms_level_meter: top level, sequencer, accumulator and config port.
// Depends on rms_pkg, rms_decode and rms_cmpsub.
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | in_sample_word, in_last_in_window
//  out     | output    | out_valid/out_stall| out_rms_level
//  cfg     | input     | psel/penable/pready| paddr, pwrite, pwdata, prdata
//
// A sample that does not close the window passes through accept, square and add.
// A closing sample adds 62 restoring divide steps and 31 root steps, both on the
// shared compare-subtract unit, then loads the output once out_stall lets it.
// Synchronous active-low reset clears sum, count, format (to 16-bit) and control.
// in_stall is high while a transaction is in work; out_stall holds the result.
`timescale 1ns / 1ps

module windowed_rms_level_meter import rms_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [23:0] in_sample_word,
  input  logic        in_last_in_window,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [23:0] out_rms_level,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  state_t              state_r, state_nxt;
  logic [1:0]          fmt_r;
  logic [MAG_W-1:0]    mag, mag_r;
  logic [SQ_W-1:0]     sq_r;
  logic                last_r, take_r;
  logic [SUM_W-1:0]    sum_r, sum_new;
  logic [SUM_W:0]      sum_add;
  logic [CNT_W-1:0]    cnt_r;
  logic [SUM_W-1:0]    q_r;
  logic [REM_W-1:0]    rem_r;
  logic [ROOT_W-1:0]   root_r;
  logic [STEP_W-1:0]   step_r;
  logic                out_valid_r;
  logic [23:0]         out_level_r;
  logic [UNIT_W-1:0]   unit_a, unit_b;
  cmpsub_res_t         unit_res;
  logic                in_acc, out_free;

  rms_decode u_decode (
    .fmt  (fmt_r),
    .word (in_sample_word),
    .mag  (mag)
  );

  rms_cmpsub u_cmpsub (
    .a   (unit_a),
    .b   (unit_b),
    .res (unit_res)
  );

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SAMPLE_FORMAT) ? {30'd0, fmt_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= FMT_S16;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_SAMPLE_FORMAT) begin
      fmt_r <= pwdata[1:0];
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_rms_level = out_level_r;
  assign out_free  = !out_valid_r || !out_stall;

  assign sum_add = {1'b0, sum_r} + (SUM_W+1)'(sq_r);
  assign sum_new = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];

  // operands of the shared unit: divide step or root step
  always_comb begin
    if (state_r == S_ROOT) begin
      unit_a = {rem_r, q_r[SUM_W-1 -: 2]};
      unit_b = UNIT_W'({root_r, 2'b01});
    end else begin
      unit_a = UNIT_W'({rem_r[CNT_W-1:0], q_r[SUM_W-1]});
      unit_b = UNIT_W'(cnt_r);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc) state_nxt = S_SQR;
      S_SQR:   state_nxt = S_ACC;
      S_ACC:   state_nxt = last_r ? S_DIV : S_IDLE;
      S_DIV:   if (step_r == '0) state_nxt = S_ROOT;
      S_ROOT:  if (step_r == '0) state_nxt = S_OUT;
      S_OUT:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sum_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_ACC && take_r) begin
        sum_r <= sum_new;
        cnt_r <= cnt_r + 1'b1;
      end
      if (state_r == S_OUT && out_free) begin
        sum_r       <= '0;
        cnt_r       <= '0;
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          mag_r  <= mag;
          last_r <= in_last_in_window;
          take_r <= (cnt_r < MAX_WINDOW_SAMPLES);
        end
      end
      S_SQR: begin
        sq_r <= SQ_W'(mag_r * mag_r);
      end
      S_ACC: begin
        q_r    <= take_r ? sum_new : sum_r;
        rem_r  <= '0;
        step_r <= DIV_STEPS_M1;
      end
      S_DIV: begin
        // restoring divide: quotient bits shift into q_r from the right
        q_r <= {q_r[SUM_W-2:0], unit_res.ge};
        if (step_r == '0) begin
          rem_r  <= '0;
          root_r <= '0;
          step_r <= ROOT_STEPS_M1;
        end else begin
          rem_r  <= unit_res.ge ? REM_W'(unit_res.diff[CNT_W-1:0])
                                : REM_W'({rem_r[CNT_W-2:0], q_r[SUM_W-1]});
          step_r <= step_r - 1'b1;
        end
      end
      S_ROOT: begin
        // two radicand bits per step off the top of q_r
        rem_r  <= unit_res.ge ? unit_res.diff[REM_W-1:0] : unit_a[REM_W-1:0];
        root_r <= {root_r[ROOT_W-2:0], unit_res.ge};
        q_r    <= {q_r[SUM_W-3:0], 2'b00};
        step_r <= step_r - 1'b1;
      end
      S_OUT: begin
        if (out_free) out_level_r <= root_r[23:0];
      end
      default: ;
    endcase
  end

  // a division step never sees an empty window
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> cnt_r != '0)
    else $error("divide by zero count");

  // level never exceeds full scale
  a_full_scale: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_rms_level <= 24'h800000)
    else $error("rms level above full scale");

  // an accepted transaction blocks the input until its work is done
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted twice in a row");

  // a result is only loaded from the output state
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_OUT))
    else $error("result raised outside output state");

endmodule

@@ tb/tb_windowed_rms_level_meter.sv @@
// tb_windowed_rms_level_meter: self-checking testbench for the windowed RMS level meter.
// Depends on rms_pkg and windowed_rms_level_meter; predicts each window's level and
// checks every result transaction in order.
`timescale 1ns / 1ps

module tb_windowed_rms_level_meter import rms_pkg::*; ();

  localparam int SETTLE_CYCLES = 100;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [23:0] in_sample_word = '0;
  logic        in_last_in_window = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [23:0] out_rms_level;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // predictor state
  logic [1:0]       fmt_model = FMT_S16;
  logic [SUM_W-1:0] sum_model = '0;
  logic [CNT_W-1:0] count_model = '0;
  logic [23:0]      rms_expected[$];

  int errors = 0;
  bit gaps_on = 1'b0;
  bit stalls_on = 1'b0;
  int stall_left = 0;
  bit stall_phase = 1'b0;

  windowed_rms_level_meter DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_sample_word(in_sample_word),
    .in_last_in_window(in_last_in_window),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_rms_level(out_rms_level),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic flag_error(string what);
    errors++;
    if (errors <= 10) $display("%s", what);
  endtask

  // Magnitude of the sample once aligned to signed 24 bits
  function automatic logic [MAG_W-1:0] sample_magnitude(logic [1:0] fmt, logic [23:0] w);
    int unsigned lo;
    int unsigned mag;
    case (fmt)
      FMT_U8: begin
        lo = 32'(w[7:0]);
        mag = (lo >= 128) ? (lo - 128) << 16 : (128 - lo) << 16;
      end
      FMT_S16: begin
        lo = 32'(w[15:0]);
        mag = w[15] ? (32'h10000 - lo) << 8 : lo << 8;
      end
      FMT_S24: begin
        lo = 32'(w);
        mag = w[23] ? 32'h1000000 - lo : lo;
      end
      default: mag = 0;
    endcase
    return mag[MAG_W-1:0];
  endfunction

  // Floor square root, one result bit per pass from the top
  function automatic logic [23:0] floor_root(logic [SUM_W-1:0] x);
    logic [ROOT_W-1:0] root;
    logic [ROOT_W-1:0] trial;
    logic [63:0]       sq;
    root = '0;
    for (int b = ROOT_W - 1; b >= 0; b--) begin
      trial = root;
      trial[b] = 1'b1;
      sq = 64'(trial) * 64'(trial);
      if (sq <= 64'(x)) root = trial;
    end
    return root[23:0];
  endfunction

  task automatic absorb_sample(logic [23:0] w, logic last);
    longint unsigned mag;
    longint unsigned sq;
    if (count_model < MAX_WINDOW_SAMPLES) begin
      mag = 64'(sample_magnitude(fmt_model, w));
      sq = mag * mag;
      if (sum_model > SUM_MAX - sq) sum_model = SUM_MAX;
      else sum_model = SUM_W'(sum_model + sq);
      count_model++;
    end
    if (last) begin
      rms_expected.push_back(floor_root(sum_model / count_model));
      sum_model = '0;
      count_model = '0;
    end
  endtask

  function automatic logic [23:0] pick_word();
    logic [23:0] w;
    case ($urandom_range(0, 9))
      0, 1: begin
        case ($urandom_range(0, 7))
          0: w = 24'h000000;
          1: w = 24'hFFFFFF;
          2: w = 24'h800000;
          3: w = 24'h7FFFFF;
          4: w = 24'h008000;
          5: w = 24'h007FFF;
          6: w = 24'h000080;
          default: w = 24'h00007F;
        endcase
      end
      2, 3: begin
        w = 24'($urandom_range(0, 511)) - 24'd256;
      end
      default: w = 24'($urandom);
    endcase
    return w;
  endfunction

  // Drop valid, wait until every expected level has arrived, then let the block settle
  task automatic go_quiet(int settle);
    in_valid <= 1'b0;
    do @(posedge clk); while (rms_expected.size() != 0);
    repeat (settle) @(posedge clk);
  endtask

  task automatic send_sample(logic [23:0] w, logic last);
    int gap;
    gap = (gaps_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample_word <= w;
    in_last_in_window <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    absorb_sample(w, last);
  endtask

  task automatic send_window(int len);
    for (int i = 0; i < len; i++) send_sample(pick_word(), i == len - 1);
  endtask

  // Write the format register while idle, then read it back
  task automatic write_format(logic [1:0] fmt);
    logic [31:0] word;
    go_quiet(SETTLE_CYCLES);
    word = $urandom;
    word[1:0] = fmt;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_SAMPLE_FORMAT, 2'b00};
    pwdata <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    fmt_model = fmt;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {30'd0, fmt})
      flag_error($sformatf("sample_format readback: expected %0d, got %0h", fmt, prdata));
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_format_extremes();
    gaps_on <= 1'b1;
    stalls_on <= 1'b1;
    // reset format is 16-bit: negative full scale
    send_sample(24'h008000, 1'b1);
    write_format(FMT_U8);
    send_sample(24'h000000, 1'b1);
    send_sample(24'hFFFFFF, 1'b1);
    send_sample(24'h5A5A80, 1'b1);
    write_format(FMT_S16);
    send_sample(24'hAB7FFF, 1'b1);
    send_sample(24'hFF0000, 1'b1);
    write_format(FMT_S24);
    send_sample(24'h800000, 1'b1);
    send_sample(24'h7FFFFF, 1'b1);
    send_sample(24'hFFFFFF, 1'b1);
    // mean of squares 12.5 truncates before the root
    send_sample(24'h000003, 1'b0);
    send_sample(24'hFFFFFD, 1'b0);
    send_sample(24'h000004, 1'b0);
    send_sample(24'hFFFFFC, 1'b1);
    write_format(FMT_NONE);
    send_sample(24'h800000, 1'b0);
    send_sample(24'hFFFFFF, 1'b1);
  endtask

  task automatic test_random_phases();
    logic [1:0] order[6];
    int sent;
    int len;
    order = '{FMT_U8, FMT_NONE, FMT_S24, FMT_S16, FMT_U8, FMT_U8};
    order[4] = 2'($urandom_range(0, 3));
    order[5] = 2'($urandom_range(0, 3));
    for (int p = 0; p < 6; p++) begin
      gaps_on <= (p == 0) || ($urandom_range(0, 2) != 0);
      stalls_on <= (p == 0) || ($urandom_range(0, 2) != 0);
      write_format(order[p]);
      sent = 0;
      while (sent < 100) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 8);
        send_window(len);
        sent += len;
        // hold the sender off until the block has drained
        if (p == 2 && sent >= 50 && sent - len < 50) go_quiet(0);
      end
      // sometimes leave a window open across the format change
      if ($urandom_range(0, 1))
        repeat ($urandom_range(1, 3)) send_sample(pick_word(), 1'b0);
    end
  endtask

  task automatic test_steady_tail();
    int sent;
    int len;
    gaps_on <= 1'b0;
    stalls_on <= 1'b0;
    write_format(2'($urandom_range(0, 3)));
    sent = 0;
    while (sent < 100) begin
      len = $urandom_range(1, 8);
      send_window(len);
      sent += len;
    end
  endtask

  // result side back-pressure: stall bursts between runs without stalls
  always @(posedge clk) begin
    if (!stalls_on) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_phase = 1'($urandom_range(0, 1));
        stall_left = stall_phase ? $urandom_range(1, 16) : $urandom_range(1, 40);
      end
      stall_left--;
      out_stall <= stall_phase;
    end
  end

  always @(posedge clk) begin : check_levels
    logic [23:0] want;
    if (rst_n && out_valid && !out_stall) begin
      if (rms_expected.size() == 0) begin
        flag_error($sformatf("rms_level %0d with no transaction expected", out_rms_level));
      end else begin
        want = rms_expected.pop_front();
        if (out_rms_level !== want)
          flag_error($sformatf("rms_level: expected %0d, got %0d", want, out_rms_level));
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_format_extremes();
    test_random_phases();
    test_steady_tail();
    go_quiet(SETTLE_CYCLES);
    if (errors == 0) begin
      $display("windowed_rms_level_meter test passed");
    end else begin
      $display("windowed_rms_level_meter test failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("windowed_rms_level_meter test failed");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/rms_pkg.sv
rtl/rms_decode.sv
rtl/rms_cmpsub.sv
rtl/windowed_rms_level_meter.sv
tb/tb_windowed_rms_level_meter.sv
